### src/dnmt_pkg.sv
package dnmt_pkg;

  localparam int NODE_W = 6;
  localparam int DOMAIN_W = 32;

  typedef enum logic [1:0] {
    FN_SETUP   = 2'd0,
    FN_LOOKUP  = 2'd1,
    FN_REVERSE = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_NEW   = 2'd1,
    ST_MISS  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

endpackage

### src/domain_to_node_map_table_top.sv
// Takes one word at a time (in_ready only in S_IDLE) and walks S_SCAN, S_DRAIN, S_FIN
// before it issues the result word; func 3 goes straight to S_FIN. S_SCAN reads the
// slot memory one slot per cycle through its single read port.
// Reset: rst (synchronous) clears all slot valid bits and the node counter at once;
// slot contents are undefined until written and are never used while invalid.
module domain_to_node_map_table_top
  import dnmt_pkg::*;
#(
  parameter int NUM_NODES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          func,
  input  logic [DOMAIN_W-1:0] domain,
  input  logic [NODE_W-1:0]   node_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic [NODE_W-1:0]   node_out,
  output logic [DOMAIN_W-1:0] domain_out
);

  localparam int AW = $clog2(NUM_NODES);
  localparam int CW = $clog2(NUM_NODES + 1);
  localparam int CMPW = (AW > NODE_W) ? AW : NODE_W;

  logic [DOMAIN_W-1:0] mem_domain [NUM_NODES];
  logic [AW-1:0]       mem_node   [NUM_NODES];

  state_t              state;
  logic [AW-1:0]       idx;
  logic                cmp_vld;
  logic [AW-1:0]       cmp_idx;
  logic [DOMAIN_W-1:0] rd_domain;
  logic [AW-1:0]       rd_node;
  logic [1:0]          req_func;
  logic [DOMAIN_W-1:0] req_domain;
  logic [NODE_W-1:0]   req_node;
  logic                hit;
  logic [AW-1:0]       hit_node;
  logic [DOMAIN_W-1:0] hit_domain;
  logic                free_found;
  logic [AW-1:0]       free_slot;
  logic [CW-1:0]       count;
  logic [NUM_NODES-1:0] valid;

  logic                accept;
  logic                fin_go;
  logic                match;
  logic                direct_free;
  logic                wr_en;
  logic [1:0]          res_status;
  logic [NODE_W-1:0]   res_node;
  logic [DOMAIN_W-1:0] res_domain;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fin_go   = (state == S_FIN) && (!out_valid || out_ready);

  assign direct_free = (func_t'(func) == FN_SETUP) && (domain < DOMAIN_W'(NUM_NODES)) &&
                       !valid[domain[AW-1:0]];

  always_comb begin
    if (func_t'(req_func) == FN_REVERSE) begin
      match = cmp_vld && valid[cmp_idx] && (CMPW'(rd_node) == CMPW'(req_node));
    end else begin
      match = cmp_vld && valid[cmp_idx] && (rd_domain == req_domain);
    end
  end

  always_comb begin
    res_status = ST_MISS;
    res_node   = '0;
    res_domain = '0;
    wr_en      = 1'b0;
    unique case (req_func)
      FN_SETUP: begin
        if (hit) begin
          res_status = ST_FOUND;
          res_node   = NODE_W'(hit_node);
        end else if (free_found && count < CW'(NUM_NODES)) begin
          res_status = ST_NEW;
          res_node   = NODE_W'(count);
          wr_en      = fin_go;
        end
      end
      FN_LOOKUP: begin
        if (hit) begin
          res_status = ST_FOUND;
          res_node   = NODE_W'(hit_node);
        end
      end
      FN_REVERSE: begin
        if (hit) begin
          res_status = ST_FOUND;
          res_node   = req_node;
          res_domain = hit_domain;
        end
      end
      default: begin
        res_status = ST_MISS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_domain <= mem_domain[idx];
    rd_node   <= mem_node[idx];
    if (wr_en) begin
      mem_domain[free_slot] <= req_domain;
      mem_node[free_slot]   <= AW'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cmp_vld    <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      count      <= '0;
      valid      <= '0;
      out_valid  <= 1'b0;
    end else begin
      cmp_vld <= (state == S_SCAN);
      cmp_idx <= idx;
      if (match && !hit) begin
        hit        <= 1'b1;
        hit_node   <= rd_node;
        hit_domain <= rd_domain;
      end
      if (state == S_SCAN && !free_found && !valid[idx] &&
          func_t'(req_func) == FN_SETUP) begin
        free_found <= 1'b1;
        free_slot  <= idx;
      end
      if (out_valid && out_ready && !fin_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_func   <= func;
            req_domain <= domain;
            req_node   <= node_in;
            hit        <= 1'b0;
            idx        <= '0;
            free_found <= direct_free;
            free_slot  <= domain[AW-1:0];
            if (func_t'(func) == FN_SETUP || func_t'(func) == FN_LOOKUP ||
                func_t'(func) == FN_REVERSE) begin
              state <= S_SCAN;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          if (idx == AW'(NUM_NODES - 1)) begin
            state <= S_DRAIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            out_valid  <= 1'b1;
            status     <= res_status;
            node_out   <= res_node;
            domain_out <= res_domain;
            if (wr_en) begin
              valid[free_slot] <= 1'b1;
              count            <= count + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(count))
    else $error("slot valid count differs from node counter");

  a_alloc_free_slot: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !valid[free_slot])
    else $error("allocation into a slot already in use");

  a_new_bumps_count: assert property (@(posedge clk) disable iff (rst)
    (fin_go && res_status == ST_NEW) |=> count == $past(count) + 1'b1)
    else $error("new node without counter advance");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_MISS) |-> (node_out == '0 && domain_out == '0))
    else $error("miss result carries nonzero fields");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> !(state == S_IDLE && $past(idx) != AW'(NUM_NODES - 1)))
    else $error("scan left early");
`endif

endmodule
